/* rtl/bsb_pkg.sv */
// Shared types, constants and arithmetic helpers of the bilinear scale and blend unit.
// Used by every module in rtl/ but bsb_ram; depends on nothing.
package bsb_pkg;

	// Field widths and fixed-point format.
	localparam int COORD_W = 8;
	localparam int CHAN_W = 8;
	localparam int SIZE_W = 9;
	localparam int FRAC = 8;
	localparam int ONE = 1 << FRAC;
	localparam int PIX_W = 3 * CHAN_W;

	// Source store geometry, banked by row and column parity.
	localparam int MAX_WIDTH = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int BANK_AW = (XW - 1) + (YW - 1);
	localparam int BANK_DEPTH = 1 << BANK_AW;
	localparam int NBANK = 4;

	// Coordinate mapping divider.
	localparam int PROD_W = COORD_W + SIZE_W;
	localparam int DIV_STEPS = 4;
	localparam int DIV_STAGES = (PROD_W + FRAC + DIV_STEPS - 1) / DIV_STEPS;
	localparam int WORK_W = DIV_STAGES * DIV_STEPS;
	localparam int IDX_W = WORK_W - FRAC;

	// Interpolation widths.
	localparam int H_W = CHAN_W + FRAC;

	// Queues.
	localparam int QDEPTH = 4;
	localparam int Q_AW = $clog2(QDEPTH);
	localparam int OUT_DEPTH = 32;
	localparam int OUT_AW = $clog2(OUT_DEPTH);

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_BLEND = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		REG_SRC_W = 2'd0,
		REG_SRC_H = 2'd1,
		REG_DST_W = 2'd2,
		REG_DST_H = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [SIZE_W-1:0] sw;
		logic [SIZE_W-1:0] sh;
		logic [SIZE_W-1:0] tw;
		logic [SIZE_W-1:0] th;
	} cfg_t;

	typedef struct packed {
		kind_t               kind;
		logic [COORD_W-1:0]  px;
		logic [COORD_W-1:0]  py;
		logic [PIX_W-1:0]    rgb;
	} in_t;

	typedef struct packed {
		in_t                 in;
		logic [PROD_W-1:0]   prod_x;
		logic [PROD_W-1:0]   prod_y;
	} item_t;

	typedef struct packed {
		logic [SIZE_W-1:0] rem;
		logic [WORK_W-1:0] work;
	} div_st_t;

	typedef struct packed {
		logic [COORD_W-1:0] p0;
		logic [COORD_W-1:0] p1;
		logic [FRAC-1:0]    f;
	} axis_t;

	// A size of zero acts as one; a size above the limit acts as the limit.
	function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
			logic [SIZE_W-1:0] lim);
		if (v == '0) return SIZE_W'(1);
		if (v > lim) return lim;
		return v;
	endfunction

	// One restoring division step: shift one dividend bit in, one quotient bit out.
	function automatic div_st_t div_step(div_st_t s, logic [SIZE_W-1:0] d);
		logic [SIZE_W:0] t;
		div_st_t r;
		t = {s.rem, s.work[WORK_W-1]};
		r.work = {s.work[WORK_W-2:0], 1'b0};
		if (t >= {1'b0, d}) begin
			r.rem = SIZE_W'(t - {1'b0, d});
			r.work[0] = 1'b1;
		end else begin
			r.rem = t[SIZE_W-1:0];
		end
		return r;
	endfunction

	// Split a scaled coordinate into neighbor indexes and fraction, clamped to the edge.
	function automatic axis_t map_axis(logic [WORK_W-1:0] q, logic [SIZE_W-1:0] n);
		logic [IDX_W-1:0]  i;
		logic [SIZE_W-1:0] last;
		logic [SIZE_W-1:0] p0w;
		logic [SIZE_W-1:0] nxt;
		axis_t r;
		i = q[WORK_W-1:FRAC];
		last = n - 1'b1;
		if (i >= IDX_W'(n)) begin
			p0w = last;
			r.f = '0;
		end else begin
			p0w = SIZE_W'(i);
			r.f = q[FRAC-1:0];
		end
		nxt = p0w + 1'b1;
		r.p0 = p0w[COORD_W-1:0];
		r.p1 = (nxt < n) ? nxt[COORD_W-1:0] : last[COORD_W-1:0];
		return r;
	endfunction

	// Horizontal weight: a*(1-f) + b*f, exact with FRAC fraction bits.
	function automatic logic [H_W-1:0] lerp_h(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
			logic [FRAC-1:0] f);
		logic [FRAC:0]     w;
		logic [H_W:0]      pa;
		logic [H_W:0]      pb;
		w = (FRAC+1)'(ONE) - {1'b0, f};
		pa = (H_W+1)'(a) * (H_W+1)'(w);
		pb = (H_W+1)'(b) * (H_W+1)'(f);
		return H_W'(pa + pb);
	endfunction

	// Vertical weight, truncated back to FRAC fraction bits.
	function automatic logic [H_W-1:0] lerp_v(logic [H_W-1:0] a, logic [H_W-1:0] b,
			logic [FRAC-1:0] f);
		logic [FRAC:0]       w;
		logic [H_W+FRAC:0]   pa;
		logic [H_W+FRAC:0]   pb;
		logic [H_W+FRAC:0]   s;
		w = (FRAC+1)'(ONE) - {1'b0, f};
		pa = (H_W+FRAC+1)'(a) * (H_W+FRAC+1)'(w);
		pb = (H_W+FRAC+1)'(b) * (H_W+FRAC+1)'(f);
		s = pa + pb;
		return H_W'(s >> FRAC);
	endfunction

	// Floor of the average of the destination channel and the sampled value.
	function automatic logic [CHAN_W-1:0] blend(logic [CHAN_W-1:0] d, logic [H_W-1:0] v);
		logic [H_W:0] s;
		s = {1'b0, d, {FRAC{1'b0}}} + {1'b0, v};
		return s[H_W:FRAC+1];
	endfunction

	// Channel c of a packed pixel: 2 is red, 1 green, 0 blue.
	function automatic logic [CHAN_W-1:0] chan(logic [PIX_W-1:0] pix, int c);
		return pix[c*CHAN_W +: CHAN_W];
	endfunction

endpackage

/* rtl/bilinear_scale_blend_unit.sv */
// Top level of the bilinear scale and blend unit: configuration registers,
// front end and back end. Depends on bsb_pkg, bsb_front, bsb_back.
//
// Usage. Input items enter through push/full like a queue write; kind 0 loads
// one source pixel into the image store, kind 1 blends one destination pixel
// with a bilinear sample of the stored source. Results leave through
// empty/pop like a queue read, one per blend item, none per load, in order.
// Size registers are written through cfg_wen/cfg_index/cfg_data while idle.
// Throughput is one item per cycle while the receiver keeps popping results,
// set by the four-bank source store that delivers all four neighbors in one
// read and by the pipelined dividers. From acceptance to the result appearing
// (empty low), an item passes the front input register, the front queue write,
// the issue register, a 7-stage divider per axis, the map stage, the registered
// store read, two interpolation stages and the result queue write.
// Reset sets all size registers to 256 and empties both queues; the store
// contents are undefined until loaded, and no clearing pass runs.
// When the receiver stalls, up to 32 results collect in the result queue;
// blends then wait in the front queue and full rises. A load at the head of
// the front queue still issues, but a waiting blend holds back all behind it.
module bilinear_scale_blend_unit import bsb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              kind,
	input  logic [COORD_W-1:0] pos_x,
	input  logic [COORD_W-1:0] pos_y,
	input  logic [CHAN_W-1:0] red_in,
	input  logic [CHAN_W-1:0] green_in,
	input  logic [CHAN_W-1:0] blue_in,
	output logic              empty,
	input  logic              pop,
	output logic [CHAN_W-1:0] red_out,
	output logic [CHAN_W-1:0] green_out,
	output logic [CHAN_W-1:0] blue_out,
	input  logic              cfg_wen,
	input  logic [1:0]        cfg_index,
	input  logic [SIZE_W-1:0] cfg_data
);

	logic [SIZE_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	cfg_t              cfg;
	in_t               in_item;
	logic              q_valid;
	item_t             q_head;
	logic              q_pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SIZE_W'(256);
			src_h_q <= SIZE_W'(256);
			dst_w_q <= SIZE_W'(256);
			dst_h_q <= SIZE_W'(256);
		end else if (cfg_wen) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SRC_W: src_w_q <= cfg_data;
				REG_SRC_H: src_h_q <= cfg_data;
				REG_DST_W: dst_w_q <= cfg_data;
				REG_DST_H: dst_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective sizes after clamping to the legal range.
	assign cfg.sw = clamp_size(src_w_q, SIZE_W'(MAX_WIDTH));
	assign cfg.sh = clamp_size(src_h_q, SIZE_W'(MAX_HEIGHT));
	assign cfg.tw = clamp_size(dst_w_q, SIZE_W'(MAX_WIDTH));
	assign cfg.th = clamp_size(dst_h_q, SIZE_W'(MAX_HEIGHT));

	assign in_item.kind = kind_t'(kind);
	assign in_item.px = pos_x;
	assign in_item.py = pos_y;
	assign in_item.rgb = {red_in, green_in, blue_in};

	bsb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_item (in_item),
		.cfg     (cfg),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop)
	);

	bsb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

endmodule

/* rtl/bsb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the source image banks.
module bsb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* rtl/bsb_div.sv */
// Pipelined restoring divider for the coordinate mapping, DIV_STEPS bits per stage.
// Depends on bsb_pkg.
module bsb_div import bsb_pkg::*; (
	input  logic              clk,
	input  logic [WORK_W-1:0] num,
	input  logic [SIZE_W-1:0] den,
	output logic [WORK_W-1:0] quo
);

	div_st_t           st_q  [DIV_STAGES];
	logic [SIZE_W-1:0] den_q [DIV_STAGES];
	div_st_t           in_st [DIV_STAGES];
	logic [SIZE_W-1:0] in_den [DIV_STAGES];
	div_st_t           nxt_st [DIV_STAGES];

	assign in_st[0] = '{rem: '0, work: num};
	assign in_den[0] = den;

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
		if (s > 0) begin : g_link
			assign in_st[s] = st_q[s-1];
			assign in_den[s] = den_q[s-1];
		end

		// DIV_STEPS dependent subtract-and-compare steps per stage.
		always_comb begin
			div_st_t t;
			t = in_st[s];
			for (int k = 0; k < DIV_STEPS; k++) begin
				t = div_step(t, in_den[s]);
			end
			nxt_st[s] = t;
		end

		always_ff @(posedge clk) begin
			st_q[s] <= nxt_st[s];
			den_q[s] <= in_den[s];
		end
	end

	assign quo = st_q[DIV_STAGES-1].work;

endmodule

/* rtl/bsb_front.sv */
// Front end: accepts input items, forms the scaled coordinate products, and
// queues the items for the back end. Depends on bsb_pkg.
module bsb_front import bsb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  in_t   in_item,
	input  cfg_t  cfg,
	output logic  q_valid,
	output item_t q_head,
	input  logic  q_pop
);

	logic            valid_s1;
	in_t             item_s1;
	item_t           new_item;
	item_t           mem_q [QDEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;
	logic            accept;

	// Room is reserved for the staged item as well as the incoming one.
	assign full = (32'(cnt_q) + 32'(valid_s1)) >= QDEPTH;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	// Products of the destination position and the source size.
	always_comb begin
		new_item.in = item_s1;
		new_item.prod_x = PROD_W'(item_s1.px) * PROD_W'(cfg.sw);
		new_item.prod_y = PROD_W'(item_s1.py) * PROD_W'(cfg.sh);
	end

	// Short queue between front and back.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			mem_q[wr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				wr_q <= wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (Q_AW+1)'(valid_s1) - (Q_AW+1)'(q_pop);
		end
	end

	assign q_valid = (cnt_q != '0);
	assign q_head = mem_q[rd_q];

`ifndef SYNTHESIS
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !q_pop) |-> (32'(cnt_q) < QDEPTH))
		else $error("front queue written while full");
`endif

endmodule

/* rtl/bsb_back.sv */
// Back end: maps coordinates, reads or writes the banked source store,
// interpolates, blends and queues results. Depends on bsb_pkg, bsb_div, bsb_ram.
module bsb_back import bsb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              q_valid,
	input  item_t             q_head,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output logic [CHAN_W-1:0] red_out,
	output logic [CHAN_W-1:0] green_out,
	output logic [CHAN_W-1:0] blue_out
);

	logic              valid_s1;
	item_t             item_s1;
	logic [WORK_W-1:0] quo_x;
	logic [WORK_W-1:0] quo_y;
	logic              side_v_q [DIV_STAGES];
	in_t               side_q   [DIV_STAGES];
	logic              valid_s2;
	in_t               in_s2;
	axis_t             ax_s2;
	axis_t             ay_s2;
	logic              valid_s3;
	logic              x0b_s3, x1b_s3, y0b_s3, y1b_s3;
	logic [FRAC-1:0]   fx_s3, fy_s3;
	logic [PIX_W-1:0]  rgb_s3;
	logic [PIX_W-1:0]  bank_rd [NBANK];
	logic              valid_s4;
	logic [H_W-1:0]    top_s4 [3];
	logic [H_W-1:0]    bot_s4 [3];
	logic [FRAC-1:0]   fy_s4;
	logic [PIX_W-1:0]  rgb_s4;
	logic              valid_s5;
	logic [H_W-1:0]    v_s5 [3];
	logic [PIX_W-1:0]  rgb_s5;
	logic [PIX_W-1:0]  res_pix;
	logic [PIX_W-1:0]  ofifo_q [OUT_DEPTH];
	logic [OUT_AW-1:0] owr_q;
	logic [OUT_AW-1:0] ord_q;
	logic [OUT_AW:0]   ocnt_q;
	logic [OUT_AW:0]   resv_q;
	logic              issue_blend;
	logic              out_pop;
	logic              load_ok;

	// Issue: a blend needs a reserved result slot, a load goes at once.
	assign q_pop = q_valid && (q_head.in.kind == KIND_LOAD || 32'(resv_q) < OUT_DEPTH);
	assign issue_blend = q_pop && q_head.in.kind == KIND_BLEND;
	assign out_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= q_head;
	end

	// Coordinate division, one unit per axis.
	bsb_div u_div_x (
		.clk (clk),
		.num (WORK_W'({item_s1.prod_x, {FRAC{1'b0}}})),
		.den (cfg.tw),
		.quo (quo_x)
	);

	bsb_div u_div_y (
		.clk (clk),
		.num (WORK_W'({item_s1.prod_y, {FRAC{1'b0}}})),
		.den (cfg.th),
		.quo (quo_y)
	);

	// Item fields travel beside the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				side_v_q[i] <= 1'b0;
			end
		end else begin
			side_v_q[0] <= valid_s1;
			for (int i = 1; i < DIV_STAGES; i++) begin
				side_v_q[i] <= side_v_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= item_s1.in;
		for (int i = 1; i < DIV_STAGES; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	// Map stage: neighbor indexes and fractions, clamped to the source edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= side_v_q[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		in_s2 <= side_q[DIV_STAGES-1];
		ax_s2 <= map_axis(quo_x, cfg.sw);
		ay_s2 <= map_axis(quo_y, cfg.sh);
	end

	// Store access: loads write one bank, blends read all four neighbors at once.
	assign load_ok = valid_s2 && in_s2.kind == KIND_LOAD
		&& {1'b0, in_s2.px} < (COORD_W+1)'(MAX_WIDTH)
		&& {1'b0, in_s2.py} < (COORD_W+1)'(MAX_HEIGHT);

	for (genvar k = 0; k < NBANK; k++) begin : g_bank
		logic               we;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;

		assign we = load_ok && in_s2.px[0] == 1'(k) && in_s2.py[0] == 1'(k >> 1);
		assign col = (ax_s2.p0[0] == 1'(k)) ? ax_s2.p0 : ax_s2.p1;
		assign row = (ay_s2.p0[0] == 1'(k >> 1)) ? ay_s2.p0 : ay_s2.p1;

		bsb_ram #(
			.WIDTH (PIX_W),
			.DEPTH (BANK_DEPTH)
		) u_ram (
			.clk     (clk),
			.wr_en   (we),
			.wr_addr ({in_s2.py[YW-1:1], in_s2.px[XW-1:1]}),
			.wr_data (in_s2.rgb),
			.rd_addr ({row[YW-1:1], col[XW-1:1]}),
			.rd_data (bank_rd[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2 && in_s2.kind == KIND_BLEND;
		end
	end

	always_ff @(posedge clk) begin
		x0b_s3 <= ax_s2.p0[0];
		x1b_s3 <= ax_s2.p1[0];
		y0b_s3 <= ay_s2.p0[0];
		y1b_s3 <= ay_s2.p1[0];
		fx_s3 <= ax_s2.f;
		fy_s3 <= ay_s2.f;
		rgb_s3 <= in_s2.rgb;
	end

	// Horizontal interpolation of the upper and lower neighbor pairs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			top_s4[c] <= lerp_h(chan(bank_rd[{y0b_s3, x0b_s3}], c),
				chan(bank_rd[{y0b_s3, x1b_s3}], c), fx_s3);
			bot_s4[c] <= lerp_h(chan(bank_rd[{y1b_s3, x0b_s3}], c),
				chan(bank_rd[{y1b_s3, x1b_s3}], c), fx_s3);
		end
		fy_s4 <= fy_s3;
		rgb_s4 <= rgb_s3;
	end

	// Vertical interpolation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			v_s5[c] <= lerp_v(top_s4[c], bot_s4[c], fy_s4);
		end
		rgb_s5 <= rgb_s4;
	end

	// Blend with the destination color.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			res_pix[c*CHAN_W +: CHAN_W] = blend(chan(rgb_s5, c), v_s5[c]);
		end
	end

	// Result queue; every blend in flight holds a reserved slot.
	always_ff @(posedge clk) begin
		if (valid_s5) begin
			ofifo_q[owr_q] <= res_pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q <= '0;
			ord_q <= '0;
			ocnt_q <= '0;
			resv_q <= '0;
		end else begin
			if (valid_s5) begin
				owr_q <= owr_q + 1'b1;
			end
			if (out_pop) begin
				ord_q <= ord_q + 1'b1;
			end
			ocnt_q <= ocnt_q + (OUT_AW+1)'(valid_s5) - (OUT_AW+1)'(out_pop);
			resv_q <= resv_q + (OUT_AW+1)'(issue_blend) - (OUT_AW+1)'(out_pop);
		end
	end

	assign empty = (ocnt_q == '0);
	assign red_out = chan(ofifo_q[ord_q], 2);
	assign green_out = chan(ofifo_q[ord_q], 1);
	assign blue_out = chan(ofifo_q[ord_q], 0);

`ifndef SYNTHESIS
	a_resv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(resv_q) <= OUT_DEPTH)
		else $error("result reservations exceed queue depth");
	a_cnt_le_resv: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= resv_q)
		else $error("result queue holds an unreserved entry");
	a_blend_lands: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (32'(ocnt_q) < OUT_DEPTH || out_pop))
		else $error("result written into a full queue");
`endif

endmodule
